@@ sv/bats_pkg.sv @@
// Package for the best aligned target select block.
// Holds shared widths, constants and the controller/datapath command and status types.
package bats_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned IndexW = 4;
  localparam int unsigned CosW = 16;
  localparam int unsigned CosFracBits = 14;
  localparam int unsigned CosOne = 16384;
  localparam int unsigned DefMaxPoints = 16;

  typedef struct packed {
    logic load;
    logic prod;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic update;
    logic clear;
  } bats_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic d_zero;
    logic in_range;
  } bats_sts_t;
endpackage

@@ sv/best_aligned_target_select.sv @@
// Top level of the best aligned target select block.
// Depends on bats_pkg, bats_ctrl and bats_datapath.
//
//   channel | signals                                        | direction
//   input   | in_valid_i/in_ready_o, point/ref fields, end   | in
//   result  | out_valid_o/out_ready_i, found, index, x, y    | out
//
// A candidate runs through the product, square root, divide and update states between
// one accepted beat and the next, with 33 square root steps and 48 divider steps. A
// zero-length candidate skips the divider, and one past the list limit skips both.
// A beat with list_end set adds a result state, held until the result is taken.
// Reset clears the running best; no clearing pass is needed.
module best_aligned_target_select import bats_pkg::*; #(
  parameter int unsigned MaxPoints = DefMaxPoints
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] ref_vx_i,
  input  logic signed [CoordW-1:0] ref_vy_i,
  input  logic                     list_end_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [IndexW-1:0]        best_index_o,
  output logic signed [CoordW-1:0] best_x_o,
  output logic signed [CoordW-1:0] best_y_o
);
  bats_cmd_t cmd;
  bats_sts_t sts;

  bats_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .list_end_i,
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  bats_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .point_x_i, .point_y_i, .ref_vx_i, .ref_vy_i,
    .found_o, .best_index_o, .best_x_o, .best_y_o
  );
endmodule

@@ sv/bats_datapath.sv @@
// Datapath: products, bit-pair square root, restoring divider and running maximum.
// Depends on bats_pkg; driven by bats_ctrl through bats_cmd_t.
module bats_datapath import bats_pkg::*; #(
  parameter int unsigned MaxPoints = DefMaxPoints
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bats_cmd_t                cmd_i,
  output bats_sts_t                sts_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] ref_vx_i,
  input  logic signed [CoordW-1:0] ref_vy_i,
  output logic                     found_o,
  output logic [IndexW-1:0]        best_index_o,
  output logic signed [CoordW-1:0] best_x_o,
  output logic signed [CoordW-1:0] best_y_o
);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  logic signed [CoordW-1:0] px_q, py_q, vx_q, vy_q;
  logic [32:0] p2_q, v2_q;
  logic signed [33:0] dot_q;
  logic [65:0] rad_q;
  logic [32:0] root_q;
  logic [5:0] sq_cnt_q;
  logic [47:0] num_q;
  logic [47:0] quo_q;
  logic [33:0] rem_q;
  logic [5:0] dv_cnt_q;
  logic signed [CosW-1:0] best_cos_q;
  logic [IndexW-1:0] best_pos_q;
  logic signed [CoordW-1:0] best_px_q, best_py_q;
  logic have_q;
  logic [CntW-1:0] cnt_q;

  logic [34:0] rem_sh;
  logic [47:0] qsat;
  logic [14:0] mag;
  logic signed [CosW-1:0] cosv;

  assign rem_sh = {rem_q, num_q[47]};
  assign qsat = quo_q;
  assign mag = (qsat > 48'(CosOne)) ? 15'(CosOne) : qsat[14:0];
  assign cosv = dot_q[33] ? -CosW'(signed'({1'b0, mag})) : CosW'(signed'({1'b0, mag}));

  logic [33:0] dot_abs;
  assign dot_abs = dot_q[33] ? 34'(-dot_q) : 34'(dot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      vx_q <= ref_vx_i;
      vy_q <= ref_vy_i;
    end
    if (cmd_i.prod) begin
      p2_q <= 33'(px_q * px_q) + 33'(py_q * py_q);
      v2_q <= 33'(vx_q * vx_q) + 33'(vy_q * vy_q);
      dot_q <= 34'(px_q * vx_q) + 34'(py_q * vy_q);
    end
    if (cmd_i.sqrt_start) begin
      rad_q <= 66'(p2_q * v2_q);
      root_q <= '0;
      rem_q <= '0;
      sq_cnt_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[63:0], 2'b00};
      sq_cnt_q <= sq_cnt_q + 6'd1;
      if (!({rem_q[31:0], rad_q[65:64]} < {root_q[31:0], 2'b01})) begin
        rem_q <= 34'({rem_q[31:0], rad_q[65:64]} - {root_q[31:0], 2'b01});
        root_q <= {root_q[31:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], rad_q[65:64]};
        root_q <= {root_q[31:0], 1'b0};
      end
    end
    if (cmd_i.div_start) begin
      num_q <= 48'({dot_abs, 14'd0}) + 48'(root_q[32:1]);
      quo_q <= '0;
      rem_q <= '0;
      dv_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[46:0], 1'b0};
      dv_cnt_q <= dv_cnt_q + 6'd1;
      if (rem_sh >= 35'(root_q)) begin
        rem_q <= 34'(rem_sh - 35'(root_q));
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= rem_sh[33:0];
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cos_q <= {1'b1, {(CosW-1){1'b0}}};
      best_pos_q <= '0;
      best_px_q <= '0;
      best_py_q <= '0;
      have_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      best_cos_q <= {1'b1, {(CosW-1){1'b0}}};
      best_pos_q <= '0;
      best_px_q <= '0;
      best_py_q <= '0;
      have_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.update) begin
      if (sts_o.in_range) begin
        cnt_q <= cnt_q + CntW'(1);
        if (root_q != '0 && cosv > best_cos_q) begin
          best_cos_q <= cosv;
          best_pos_q <= IndexW'(cnt_q);
          best_px_q <= px_q;
          best_py_q <= py_q;
          have_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.sqrt_done = (sq_cnt_q == 6'd33);
  assign sts_o.div_done = (dv_cnt_q == 6'd47);
  assign sts_o.d_zero = (root_q == '0);
  assign sts_o.in_range = (cnt_q < CntW'(MaxPoints));

  assign found_o = have_q;
  assign best_index_o = best_pos_q;
  assign best_x_o = best_px_q;
  assign best_y_o = best_py_q;
endmodule

@@ sv/bats_ctrl.sv @@
// Controller state machine sequencing one candidate through the datapath.
// Depends on bats_pkg; drives bats_datapath through bats_cmd_t.
module bats_ctrl import bats_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      list_end_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bats_cmd_t cmd_o,
  input  bats_sts_t sts_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_SQ0, S_SQRT, S_DIV0, S_DIV, S_UPD, S_OUT
  } state_e;

  state_e state_q;
  logic last_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_PROD: cmd_o.prod = 1'b1;
      S_SQ0: cmd_o.sqrt_start = 1'b1;
      S_SQRT: cmd_o.sqrt_step = !sts_i.sqrt_done;
      S_DIV0: cmd_o.div_start = 1'b1;
      S_DIV: cmd_o.div_step = 1'b1;
      S_UPD: cmd_o.update = 1'b1;
      S_OUT: cmd_o.clear = out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q <= list_end_i;
            state_q <= S_PROD;
          end
        end
        S_PROD: state_q <= sts_i.in_range ? S_SQ0 : S_UPD;
        S_SQ0: state_q <= S_SQRT;
        S_SQRT: begin
          if (sts_i.sqrt_done) begin
            state_q <= sts_i.d_zero ? S_UPD : S_DIV0;
          end
        end
        S_DIV0: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: state_q <= last_q ? S_OUT : S_IDLE;
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ tb/tb_best_aligned_target_select.sv @@
// Testbench for best_aligned_target_select: streams candidate lists and checks each
// reported winner against a cosine-argmax predictor. Depends on bats_pkg and the RTL.
`timescale 1ns / 100ps

module tb_best_aligned_target_select import bats_pkg::*;;

  typedef struct packed {
    logic                     found;
    logic [IndexW-1:0]        index;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } winner_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic signed [CoordW-1:0] ref_vx_i = '0;
  logic signed [CoordW-1:0] ref_vy_i = '0;
  logic list_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o;
  logic [IndexW-1:0] best_index_o;
  logic signed [CoordW-1:0] best_x_o;
  logic signed [CoordW-1:0] best_y_o;

  winner_t winners_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  bit stall_on = 1'b1;

  logic signed [CosW-1:0] top_cos;
  logic [IndexW-1:0] top_pos;
  logic signed [CoordW-1:0] top_x, top_y;
  logic top_valid;
  int unsigned position;

  localparam int Watchdog = 20000;

  always #4 clk_i = ~clk_i;

  best_aligned_target_select dut (.*);

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic clear_best();
    top_cos = -16'sd32768;
    top_pos = '0;
    top_x = '0;
    top_y = '0;
    top_valid = 1'b0;
    position = 0;
  endtask

  task automatic score_candidate(logic signed [15:0] px, logic signed [15:0] py,
                                 logic signed [15:0] vx, logic signed [15:0] vy,
                                 logic last);
    longint p2, v2, dot;
    logic [63:0] d, mag, q;
    logic signed [CosW-1:0] c;
    winner_t w;
    if (position < DefMaxPoints) begin
      p2 = longint'(px) * px + longint'(py) * py;
      v2 = longint'(vx) * vx + longint'(vy) * vy;
      d = root64(p2 * v2);
      if (d != 0) begin
        dot = longint'(px) * vx + longint'(py) * vy;
        mag = (dot < 0) ? -dot : dot;
        q = ((mag << CosFracBits) + (d >> 1)) / d;
        if (q > 64'(CosOne)) q = 64'(CosOne);
        c = (dot < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
        if (c > top_cos) begin
          top_cos = c;
          top_pos = position[IndexW-1:0];
          top_x = px;
          top_y = py;
          top_valid = 1'b1;
        end
      end
      position++;
    end
    if (last) begin
      if (top_valid) begin
        w = '{1'b1, top_pos, top_x, top_y};
      end else begin
        w = '0;
      end
      winners_q = {winners_q, w};
      clear_best();
    end
  endtask

  task automatic send_candidate(logic signed [15:0] px, logic signed [15:0] py,
                                logic signed [15:0] vx, logic signed [15:0] vy,
                                logic last);
    int gap;
    if (burst_left == 0) begin
      gap = int'($urandom_range(0, 6));
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = int'($urandom_range(1, 12));
    end
    burst_left--;
    in_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    ref_vx_i <= vx;
    ref_vy_i <= vy;
    list_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    score_candidate(px, py, vx, vy, last);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (winners_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_candidate(16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1);
    send_candidate(16'sd0, 16'sd0, 16'sd256, 16'sd0, 1'b0);
    send_candidate(16'sd100, 16'sd100, 16'sd0, 16'sd0, 1'b1);
    send_candidate(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0);
    send_candidate(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_candidate(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_candidate(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b0);
    send_candidate(16'sd5, 16'sd0, -16'sd3, 16'sd7, 1'b0);
    send_candidate(16'sd1, 16'sd1, 16'sd1, -16'sd1, 1'b1);
    send_candidate(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_candidate(16'sd10, 16'sd0, 16'sd10, 16'sd0, 1'b0);
    send_candidate(16'sd0, 16'sd10, 16'sd10, 16'sd0, 1'b0);
    send_candidate(16'sd0, 16'sd10, 16'sd0, 16'sd10, 1'b1);
    wait_drained();
  endtask

  task automatic test_overflow_list();
    for (int i = 0; i < 20; i++)
      send_candidate(16'($urandom), 16'($urandom), 16'sd300, -16'sd200, i == 19);
    for (int i = 0; i < 18; i++)
      send_candidate(i == 17 ? 16'sd300 : -16'sd5, 16'sd0, 16'sd300, 16'sd0, i == 17);
    wait_drained();
  endtask

  task automatic test_random_lists();
    logic signed [15:0] vx, vy;
    int len, n;
    n = 0;
    while (n < 500) begin
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(14, 20))
                                        : int'($urandom_range(1, 6));
      vx = 16'($urandom);
      vy = 16'($urandom);
      if ($urandom_range(0, 7) == 0) vx = 16'(int'($urandom_range(0, 2)) - 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          vx = 16'($urandom);
          vy = 16'($urandom);
        end
        case ($urandom_range(0, 5))
          0: send_candidate(16'sd0, 16'sd0, vx, vy, i == len - 1);
          1: send_candidate(vx, vy, vx, vy, i == len - 1);
          2: send_candidate(16'(int'($urandom_range(0, 8)) - 4),
                            16'(int'($urandom_range(0, 8)) - 4), vx, vy, i == len - 1);
          default: send_candidate(16'($urandom), 16'($urandom), vx, vy, i == len - 1);
        endcase
        n++;
        if (n == 250) wait_drained();
      end
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if ($urandom_range(0, 49) == 0) stall_mode = int'($urandom_range(0, 2));
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        stall_on = ~stall_on;
        out_ready_i <= stall_on;
      end
    endcase
  end

  always @(posedge clk_i) begin
    winner_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (winners_q.size() == 0) begin
        $display("%0t: unexpected result found=%0b index=%0d x=%0d y=%0d", $time,
                 found_o, best_index_o, best_x_o, best_y_o);
        errors++;
      end else begin
        w = winners_q.pop_front();
        if (found_o !== w.found) begin
          $display("%0t: found expected %0b actual %0b", $time, w.found, found_o);
          errors++;
        end
        if (best_index_o !== w.index) begin
          $display("%0t: best_index expected %0d actual %0d", $time, w.index, best_index_o);
          errors++;
        end
        if (best_x_o !== w.x) begin
          $display("%0t: best_x expected %0d actual %0d", $time, w.x, best_x_o);
          errors++;
        end
        if (best_y_o !== w.y) begin
          $display("%0t: best_y expected %0d actual %0d", $time, w.y, best_y_o);
          errors++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= Watchdog) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_best();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow_list();
    test_random_lists();
    if (errors == 0 && winners_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ best_aligned_target_select.f @@
sv/bats_pkg.sv
sv/bats_datapath.sv
sv/bats_ctrl.sv
sv/best_aligned_target_select.sv
tb/tb_best_aligned_target_select.sv
